FILE: rtl/deq_pkg.sv
// deq_pkg: sizes, codes and transfer structs for the double-ended queue
// no dependencies; imported by deq_ctrl, double_ended_queue, deq_checker and the bench
package deq_pkg;

    localparam int DEPTH      = 16;
    localparam int ELEM_WIDTH = 32;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int VALUE_W    = 32;
    localparam int COUNT_W    = 5;
    localparam int ACTION_W   = 3;
    localparam int STATUS_W   = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_LOOK       = 3'd4
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [VALUE_W-1:0]  value;
    } deq_in_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  front_value;
        logic [VALUE_W-1:0]  back_value;
        logic                is_empty;
        logic [COUNT_W-1:0]  count;
        logic [STATUS_W-1:0] status;
    } deq_out_t;

    // controller to storage
    typedef struct packed {
        logic                  we;
        logic [IDX_W-1:0]      waddr;
        logic [ELEM_WIDTH-1:0] wdata;
        logic                  re;
        logic [IDX_W-1:0]      raddr_a;
        logic [IDX_W-1:0]      raddr_b;
    } mem_req_t;

    function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        r = (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        r = (i == '0) ? IDX_W'(DEPTH - 1) : i - IDX_W'(1);
        return r;
    endfunction

endpackage

FILE: rtl/deq_ram.sv
// deq_ram: generic one-write two-read synchronous ram, registered read data
// no package dependency
module deq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

FILE: rtl/deq_ctrl.sv
// deq_ctrl: ring indices, fill count, status and sequencing of one command
// depends on deq_pkg
module deq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  deq_pkg::deq_in_t   cmd,
    output logic               busy,
    output logic               done,
    output deq_pkg::mem_req_t  mem_req,
    output logic [deq_pkg::CNT_W-1:0]    fill,
    output logic [deq_pkg::STATUS_W-1:0] status
);
    import deq_pkg::*;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] front_reg, front_next;
    logic [IDX_W-1:0] back_reg, back_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    status_t          status_reg, status_next;

    logic accept;
    logic is_push, is_pop, is_full, is_empty, do_write;

    assign accept   = start && !busy;
    assign is_push  = (cmd.action == ACT_PUSH_FRONT) || (cmd.action == ACT_PUSH_BACK);
    assign is_pop   = (cmd.action == ACT_POP_FRONT) || (cmd.action == ACT_POP_BACK);
    assign is_full  = (fill_reg == CNT_W'(DEPTH));
    assign is_empty = (fill_reg == '0);
    assign do_write = accept && is_push && !is_full;

    // index and fill update
    always_comb
    begin
        front_next  = front_reg;
        back_next   = back_reg;
        fill_next   = fill_reg;
        status_next = status_reg;
        if (accept)
        begin
            status_next = ST_DONE;
            if (is_push && is_full)
            begin
                status_next = ST_FULL;
            end
            else if (is_pop && is_empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                case (cmd.action)
                    ACT_PUSH_FRONT:
                    begin
                        front_next = step_down(front_reg);
                        fill_next  = fill_reg + CNT_W'(1);
                    end
                    ACT_PUSH_BACK:
                    begin
                        back_next = step_up(back_reg);
                        fill_next = fill_reg + CNT_W'(1);
                    end
                    ACT_POP_FRONT:
                    begin
                        front_next = step_up(front_reg);
                        fill_next  = fill_reg - CNT_W'(1);
                    end
                    ACT_POP_BACK:
                    begin
                        back_next = step_down(back_reg);
                        fill_next = fill_reg - CNT_W'(1);
                    end
                    default:
                    begin
                        fill_next = fill_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            front_reg <= '0;
            back_reg  <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            back_reg  <= back_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  state_next = accept ? S_READ : S_IDLE;
            S_READ:  state_next = S_RESP;
            S_RESP:  state_next = accept ? S_READ : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        busy = 1'b0;
        done = 1'b0;
        unique case (state_reg)
            S_IDLE:  busy = 1'b0;
            S_READ:  busy = 1'b1;
            S_RESP:  done = 1'b1;
            default: busy = 1'b0;
        endcase
    end

    // writes land on the accept edge, reads follow in the read state
    always_comb
    begin
        mem_req.we      = do_write;
        mem_req.waddr   = (cmd.action == ACT_PUSH_FRONT) ? step_down(front_reg) : back_reg;
        mem_req.wdata   = ELEM_WIDTH'(cmd.value);
        mem_req.re      = (state_reg == S_READ);
        mem_req.raddr_a = front_reg;
        mem_req.raddr_b = step_down(back_reg);
    end

    assign fill   = fill_reg;
    assign status = status_reg;

endmodule

FILE: rtl/double_ended_queue.sv
// double_ended_queue: top level of the bounded deque on a ring buffer
// depends on deq_pkg, deq_ctrl and deq_ram
//
// A command (push front, push back, pop front, pop back or look) is taken on
// the clock edge where start is high and busy is low. Exactly one result per
// command appears on result for a single cycle with done high, closing on a
// clock edge; the receiver cannot stall it, so capture it on that edge. busy
// is high for one cycle between command and result, so a new command may be
// given while done is high but not while busy is high. The pacing is set
// by the element ram: the push is written on the accept edge and the
// front and back slots are read back through its registered read ports in
// the following cycle. A push when the queue is full or a pop when it is
// empty changes nothing and reports a refused status; action codes above
// look behave as a look. front_value and back_value read as zero when the
// queue is empty.
module double_ended_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  deq_pkg::deq_in_t  cmd,
    output logic              busy,
    output logic              done,
    output deq_pkg::deq_out_t result
);
    import deq_pkg::*;

    mem_req_t              mem_req;
    logic [CNT_W-1:0]      fill;
    logic [STATUS_W-1:0]   status;
    logic [ELEM_WIDTH-1:0] rdata_front;
    logic [ELEM_WIDTH-1:0] rdata_back;
    logic                  empty;

    // sequencing, ring indices and fill count
    deq_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .cmd     (cmd),
        .busy    (busy),
        .done    (done),
        .mem_req (mem_req),
        .fill    (fill),
        .status  (status)
    );

    // element storage: one write port, two read ports for front and back
    deq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (ELEM_WIDTH)
    ) u_ram (
        .clk     (clk),
        .we      (mem_req.we),
        .waddr   (mem_req.waddr),
        .wdata   (mem_req.wdata),
        .re      (mem_req.re),
        .raddr_a (mem_req.raddr_a),
        .raddr_b (mem_req.raddr_b),
        .rdata_a (rdata_front),
        .rdata_b (rdata_back)
    );

    assign empty = (fill == '0);

    // fill and status already hold the post-command state during done
    always_comb
    begin
        result.front_value = empty ? '0 : VALUE_W'(rdata_front);
        result.back_value  = empty ? '0 : VALUE_W'(rdata_back);
        result.is_empty    = empty;
        result.count       = COUNT_W'(fill);
        result.status      = status;
    end

endmodule

FILE: rtl/deq_checker.sv
// deq_checker: port-level checks on the double-ended queue, bound to the top
// depends on deq_pkg and double_ended_queue
module deq_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input deq_pkg::deq_out_t result
);
    import deq_pkg::*;

    // an accepted command always gives its one busy cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command transfer not followed by busy");

    // busy cycle is always followed by the result transfer
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (done && !busy))
        else $error("result transfer missing after busy");

    // no result unless busy was high before it
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result transfer without a command");

    // empty result carries zeros and a zero count
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.is_empty) |->
            (result.count == '0 && result.front_value == '0 && result.back_value == '0))
        else $error("empty result with non-zero content");

    // count never exceeds the depth, a refused push means full, a refused pop means empty
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.count <= COUNT_W'(DEPTH)) &&
                 (result.status != ST_FULL || result.count == COUNT_W'(DEPTH)) &&
                 (result.status != ST_EMPTY || result.is_empty))
        else $error("count or status out of line");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

FILE: bench/double_ended_queue_tb.sv
// double_ended_queue_tb: self-checking bench for the bounded ring-buffer deque
// depends on deq_pkg for the transfer structs and codes, and on the double_ended_queue rtl
module double_ended_queue_tb;

    import deq_pkg::*;

    // action codes above look have no name in the package but must behave as a look
    localparam logic [ACTION_W-1:0] ACT_SPARE_5 = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_LIMIT = 200;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    deq_in_t  cmd = '0;
    logic     busy;
    logic     done;
    deq_out_t result;

    // shadow copy of the deque, advanced once per accepted command
    logic [ELEM_WIDTH-1:0] shadow_slots [DEPTH];
    int shadow_head = 0;
    int shadow_tail = 0;
    int shadow_fill = 0;

    // results still owed by the rtl, oldest first
    deq_out_t owed_results [$];

    int mismatches = 0;
    int commands_sent = 0;
    int results_seen = 0;
    int full_refusals = 0;
    int empty_refusals = 0;
    int look_commands = 0;
    int peak_fill = 0;

    logic [ACTION_W-1:0] look_codes [4] = '{ACT_LOOK, ACT_SPARE_5, ACT_SPARE_6, ACT_SPARE_7};

    double_ended_queue dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // generous ceiling: a clean run needs well under a tenth of this
    initial
    begin
        #2_000_000;
        $display("run timed out with %0d results still owed", owed_results.size());
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // apply one command to the shadow deque and return what the rtl should report
    function automatic deq_out_t apply_to_shadow(input deq_in_t c);
        deq_out_t r;
        status_t  st;
        int       last;
        st = ST_DONE;
        case (c.action)
            ACT_PUSH_FRONT, ACT_PUSH_BACK:
            begin
                if (shadow_fill >= DEPTH)
                begin
                    st = ST_FULL;
                    full_refusals++;
                end
                else if (c.action == ACT_PUSH_FRONT)
                begin
                    // front grows downwards round the ring
                    shadow_head = (shadow_head == 0) ? DEPTH - 1 : shadow_head - 1;
                    shadow_slots[shadow_head] = c.value[ELEM_WIDTH-1:0];
                    shadow_fill++;
                end
                else
                begin
                    // back index points one past the last element
                    shadow_slots[shadow_tail] = c.value[ELEM_WIDTH-1:0];
                    shadow_tail = (shadow_tail + 1 >= DEPTH) ? 0 : shadow_tail + 1;
                    shadow_fill++;
                end
            end
            ACT_POP_FRONT, ACT_POP_BACK:
            begin
                if (shadow_fill == 0)
                begin
                    st = ST_EMPTY;
                    empty_refusals++;
                end
                else if (c.action == ACT_POP_FRONT)
                begin
                    shadow_head = (shadow_head + 1 >= DEPTH) ? 0 : shadow_head + 1;
                    shadow_fill--;
                end
                else
                begin
                    shadow_tail = (shadow_tail == 0) ? DEPTH - 1 : shadow_tail - 1;
                    shadow_fill--;
                end
            end
            default:
                look_commands++;
        endcase

        if (shadow_fill > peak_fill)
            peak_fill = shadow_fill;

        // only occupied slots are ever read, so an unwritten slot never shows
        r = '0;
        if (shadow_fill != 0)
        begin
            last = (shadow_tail == 0) ? DEPTH - 1 : shadow_tail - 1;
            r.front_value = VALUE_W'(shadow_slots[shadow_head]);
            r.back_value  = VALUE_W'(shadow_slots[last]);
        end
        r.is_empty = (shadow_fill == 0);
        r.count    = COUNT_W'(shadow_fill);
        r.status   = st;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------

    // one command transfer; afterwards the sender idles for a random gap that grows
    // while a draw falls under idle_pct percent, otherwise start stays high for the next one
    task automatic send_cmd(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] val,
                            input int unsigned idle_pct);
        deq_in_t     c;
        int unsigned gap;
        c.action = act;
        c.value  = val;
        start <= 1'b1;
        cmd   <= c;
        // the transfer happens at the first edge where busy is low
        do
            @(posedge clk);
        while (busy !== 1'b0);
        owed_results.push_back(apply_to_shadow(c));
        commands_sent++;
        gap = 0;
        while (gap < 30 && $urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // mostly random data, now and then a pattern that sits on a field extreme
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            2:       return VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
            3:       return ~(VALUE_W'(1) << $urandom_range(0, VALUE_W - 1));
            default: return $urandom;
        endcase
    endfunction

    // push_bias steers the fill level: high fills towards full, low drains to empty
    function automatic logic [ACTION_W-1:0] pick_action(input int unsigned push_bias);
        if ($urandom_range(0, 99) < 7)
            return look_codes[$urandom_range(0, 3)];
        if ($urandom_range(0, 99) < push_bias)
            return $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
        return $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic log_mismatch(input string what, input logic [VALUE_W-1:0] want,
                                input logic [VALUE_W-1:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch on result %0d: %s expected %h got %h",
                     results_seen, what, want, got);
    endtask

    // results cannot be held off, so every done cycle is taken as a transfer
    always @(posedge clk)
    begin
        deq_out_t want;
        if (rst_n && done === 1'b1)
        begin
            results_seen++;
            if (owed_results.size() == 0)
                log_mismatch("unexpected result, front_value", '0, result.front_value);
            else
            begin
                want = owed_results.pop_front();
                if (result.front_value !== want.front_value)
                    log_mismatch("front_value", want.front_value, result.front_value);
                if (result.back_value !== want.back_value)
                    log_mismatch("back_value", want.back_value, result.back_value);
                if (result.is_empty !== want.is_empty)
                    log_mismatch("is_empty", VALUE_W'(want.is_empty), VALUE_W'(result.is_empty));
                if (result.count !== want.count)
                    log_mismatch("count", VALUE_W'(want.count), VALUE_W'(result.count));
                if (result.status !== want.status)
                    log_mismatch("status", VALUE_W'(want.status), VALUE_W'(result.status));
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // refused pops and looks on a fresh queue, including two of the unnamed codes
    task automatic test_empty_queue();
        send_cmd(ACT_POP_FRONT, '1, 0);
        send_cmd(ACT_POP_BACK, '0, 0);
        send_cmd(ACT_LOOK, 32'hA5A5_5A5A, 0);
        send_cmd(ACT_SPARE_5, '1, 1);
        send_cmd(ACT_SPARE_6, 32'h0000_0001, 0);
    endtask

    // fill to the brim from both ends, starting with extreme data, then push into a full queue and look
    task automatic test_full_queue();
        logic [VALUE_W-1:0] edge_vals [6] = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000,
                                             32'h0000_0001, 32'hAAAA_AAAA, 32'h5555_5555};
        for (int i = 0; i < DEPTH; i++)
            send_cmd(i[0] ? ACT_PUSH_BACK : ACT_PUSH_FRONT,
                     (i < 6) ? edge_vals[i] : $urandom, (i % 5 == 4) ? 50 : 0);
        send_cmd(ACT_PUSH_FRONT, '1, 0);
        send_cmd(ACT_PUSH_BACK, '0, 0);
        send_cmd(ACT_SPARE_7, '1, 0);
        // one element off each end: the front index steps up, the back index steps down
        send_cmd(ACT_POP_FRONT, $urandom, 0);
        send_cmd(ACT_POP_BACK, $urandom, 0);
    endtask

    // bursts that fill, drain or wander, so full and empty are both hit often
    task automatic test_random_mix(input int n_items, input int unsigned idle_pct);
        int          left;
        int          burst;
        int unsigned bias;
        left = n_items;
        while (left > 0)
        begin
            case ($urandom_range(0, 2))
                0:       bias = 80;
                1:       bias = 20;
                default: bias = 50;
            endcase
            burst = $urandom_range(8, 40);
            // short bursts run with no idling, even in an idling phase
            for (int i = 0; i < burst && left > 0; i++, left--)
                send_cmd(pick_action(bias), pick_value(), (burst < 12) ? 0 : idle_pct);
        end
    endtask

    initial
    begin
        int waited;
        for (int i = 0; i < DEPTH; i++)
            shadow_slots[i] = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_full_queue();

        // the receiver cannot stall, so only the sender idling changes between phases
        test_random_mix(250, 0);
        test_random_mix(250, 72);
        test_random_mix(250, 35);
        test_random_mix(250, 0);

        start <= 1'b0;

        // wait for the last results, then a little longer for any stray strobe
        waited = 0;
        while (owed_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (6) @(posedge clk);

        while (owed_results.size() != 0)
        begin
            void'(owed_results.pop_front());
            log_mismatch("missing result, nothing arrived for", '0, '0);
        end

        $display("%0d commands, %0d results checked, %0d looks, peak fill %0d of %0d",
                 commands_sent, results_seen, look_commands, peak_fill, DEPTH);
        $display("%0d pushes refused as full, %0d pops refused as empty, %0d mismatches",
                 full_refusals, empty_refusals, mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
rtl/deq_pkg.sv
rtl/deq_ram.sv
rtl/deq_ctrl.sv
rtl/double_ended_queue.sv
rtl/deq_checker.sv
bench/double_ended_queue_tb.sv
